>>> hdl/sliding_window_p95_tracker_defines.svh
// ----------------------------------------------------------------------------
// Sliding window p95 tracker assertion macros
// Concurrent assertion shorthands sampled on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_P95_TRACKER_DEFINES_SVH
`define SLIDING_WINDOW_P95_TRACKER_DEFINES_SVH

// same-cycle implication
`define SWP_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define SWP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hdl/swpt_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window p95 tracker package
// Widths, rank arithmetic constants and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package swpt_pkg;

  // window depth, power of two
  localparam int WINDOW   = 4096;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int CNT_W    = IDX_W + 1;
  localparam int SAMPLE_W = 24;

  // rank = ceil(PCT_NUM * n / PCT_DEN) - 1
  localparam int PCT_NUM  = 19;
  localparam int PCT_DEN  = 20;
  localparam int NUM_W    = CNT_W + 5;
  localparam int RECIP_SH = NUM_W + 5;
  localparam int RECIP_W  = RECIP_SH - 4;
  localparam int RECIP    = (2 ** RECIP_SH + PCT_DEN - 1) / PCT_DEN;
  localparam int PROD_W   = NUM_W + RECIP_W;

  typedef struct packed {
    logic load;
    logic ring_rd;
    logic ring_wr;
    logic scan_start;
    logic scan_del;
    logic scan_ins;
    logic del_end;
    logic tail_wr;
    logic rank_calc;
    logic p95_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
  } stat_t;

endpackage

`default_nettype wire

>>> hdl/swpt_intf.sv
// ----------------------------------------------------------------------------
// Sliding window p95 tracker channel interfaces
// Valid/ready channels for latency samples and percentile results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swpt_sample_if;
  import swpt_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] latency_us;

  modport source (output valid, output latency_us, input ready);
  modport sink   (input valid, input latency_us, output ready);
endinterface

interface swpt_result_if;
  import swpt_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] last_us;
  logic [SAMPLE_W-1:0] p95_us;
  logic [CNT_W-1:0]    sample_count;

  modport source (output valid, output last_us, output p95_us, output sample_count,
                  input ready);
  modport sink   (input valid, input last_us, input p95_us, input sample_count,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/swpt_ctrl.sv
// ----------------------------------------------------------------------------
// Sliding window p95 tracker controller
// Sequences ring update, delete and insert passes, rank lookup and result.
// ----------------------------------------------------------------------------
`default_nettype none

module swpt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swpt_pkg::cmd_t cmd_o,
  input  swpt_pkg::stat_t stat_i
);
  import swpt_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_RING_RD = 8'b0000_0010,
    S_RING_WR = 8'b0000_0100,
    S_DEL     = 8'b0000_1000,
    S_INS     = 8'b0001_0000,
    S_RANK    = 8'b0010_0000,
    S_P95     = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RING_RD;
        end
      end
      S_RING_RD: begin
        cmd_o.ring_rd = 1'b1;
        state_d       = S_RING_WR;
      end
      S_RING_WR: begin
        cmd_o.ring_wr    = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = stat_i.full ? S_DEL : S_INS;
      end
      S_DEL: begin
        cmd_o.scan_del = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.del_end    = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = S_INS;
        end
      end
      S_INS: begin
        cmd_o.scan_ins = 1'b1;
        if (stat_i.scan_done) begin
          cmd_o.tail_wr = 1'b1;
          state_d       = S_RANK;
        end
      end
      S_RANK: begin
        cmd_o.rank_calc = 1'b1;
        state_d         = S_P95;
      end
      S_P95: begin
        cmd_o.p95_rd = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/swpt_dp.sv
// ----------------------------------------------------------------------------
// Sliding window p95 tracker datapath
// Sample ring, sorted store with streaming shift passes, rank and result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module swpt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swpt_pkg::cmd_t                cmd_i,
  output swpt_pkg::stat_t               stat_o,
  input  logic [swpt_pkg::SAMPLE_W-1:0] latency_us_i,
  output logic [swpt_pkg::SAMPLE_W-1:0] last_us_o,
  output logic [swpt_pkg::SAMPLE_W-1:0] p95_us_o,
  output logic [swpt_pkg::CNT_W-1:0]    sample_count_o
);
  import swpt_pkg::*;

  logic [SAMPLE_W-1:0] ring_mem [WINDOW];
  logic [SAMPLE_W-1:0] sort_mem [WINDOW];

  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] ring_rdata_q;
  logic [SAMPLE_W-1:0] sort_rdata_q;
  logic [SAMPLE_W-1:0] carry_q, carry_d;
  logic                hit_q, hit_d;
  logic [CNT_W-1:0]    held_q, held_d;
  logic [IDX_W-1:0]    oldest_q, oldest_d;
  logic [CNT_W-1:0]    scan_idx_q, scan_idx_d;
  logic [CNT_W-1:0]    scan_len_q, scan_len_d;
  logic                rd_pend_q, rd_pend_d;
  logic [IDX_W-1:0]    rd_idx_q;
  logic [PROD_W-1:0]   rank_prod_q;

  logic                full;
  logic                scan_act;
  logic                issue;
  logic                greater;
  logic [IDX_W-1:0]    ring_waddr;
  logic [NUM_W-1:0]    rank_num;
  logic [CNT_W-1:0]    rank_quot;
  logic [CNT_W-1:0]    rank_m1;
  logic                sort_re;
  logic [IDX_W-1:0]    sort_raddr;
  logic                sort_we;
  logic [IDX_W-1:0]    sort_waddr;
  logic [SAMPLE_W-1:0] sort_wdata;

  assign full     = (held_q == CNT_W'(WINDOW));
  assign scan_act = cmd_i.scan_del || cmd_i.scan_ins;
  assign issue    = scan_act && (scan_idx_q < scan_len_q);
  assign greater  = (sort_rdata_q > sample_q);

  assign stat_o.full      = full;
  assign stat_o.scan_done = (scan_idx_q == scan_len_q) && !rd_pend_q;

  assign ring_waddr = full ? oldest_q : oldest_q + held_q[IDX_W-1:0];

  assign rank_num  = NUM_W'(held_q) * NUM_W'(PCT_NUM) + NUM_W'(PCT_NUM);
  assign rank_quot = rank_prod_q[RECIP_SH +: CNT_W];
  assign rank_m1   = rank_quot - CNT_W'(1);

  assign sort_re    = issue || cmd_i.p95_rd;
  assign sort_raddr = cmd_i.p95_rd ? rank_m1[IDX_W-1:0] : scan_idx_q[IDX_W-1:0];

  always_comb begin
    sort_we    = 1'b0;
    sort_waddr = rd_idx_q;
    sort_wdata = sort_rdata_q;
    hit_d      = hit_q;
    carry_d    = carry_q;
    if (cmd_i.scan_start) begin
      hit_d = 1'b0;
    end else if (cmd_i.scan_del && rd_pend_q) begin
      if (hit_q) begin
        sort_we    = 1'b1;
        sort_waddr = rd_idx_q - IDX_W'(1);
      end else if (sort_rdata_q == ring_rdata_q) begin
        hit_d = 1'b1;
      end
    end else if (cmd_i.scan_ins && rd_pend_q) begin
      if (hit_q) begin
        sort_we    = 1'b1;
        sort_wdata = carry_q;
        carry_d    = sort_rdata_q;
      end else if (greater) begin
        sort_we    = 1'b1;
        sort_wdata = sample_q;
        carry_d    = sort_rdata_q;
        hit_d      = 1'b1;
      end
    end else if (cmd_i.tail_wr) begin
      sort_we    = 1'b1;
      sort_waddr = held_q[IDX_W-1:0];
      sort_wdata = hit_q ? carry_q : sample_q;
    end
  end

  always_comb begin
    held_d     = held_q;
    oldest_d   = oldest_q;
    scan_idx_d = scan_idx_q;
    scan_len_d = scan_len_q;
    rd_pend_d  = issue;
    if (cmd_i.ring_wr && full) begin
      oldest_d = oldest_q + IDX_W'(1);
    end
    if (cmd_i.del_end) begin
      held_d = held_q - CNT_W'(1);
    end else if (cmd_i.tail_wr) begin
      held_d = held_q + CNT_W'(1);
    end
    if (cmd_i.scan_start) begin
      scan_idx_d = '0;
      scan_len_d = cmd_i.del_end ? held_q - CNT_W'(1) : held_q;
    end else if (issue) begin
      scan_idx_d = scan_idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      oldest_q   <= '0;
      scan_idx_q <= '0;
      scan_len_q <= '0;
      rd_pend_q  <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      held_q     <= held_d;
      oldest_q   <= oldest_d;
      scan_idx_q <= scan_idx_d;
      scan_len_q <= scan_len_d;
      rd_pend_q  <= rd_pend_d;
      hit_q      <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q  <= carry_d;
    rd_idx_q <= scan_idx_q[IDX_W-1:0];
    if (cmd_i.load) begin
      sample_q <= latency_us_i;
    end
    if (cmd_i.rank_calc) begin
      rank_prod_q <= PROD_W'(rank_num) * PROD_W'(RECIP);
    end
    if (cmd_i.out_load) begin
      last_us_o      <= sample_q;
      p95_us_o       <= sort_rdata_q;
      sample_count_o <= held_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ring_rd) begin
      ring_rdata_q <= ring_mem[oldest_q];
    end
    if (cmd_i.ring_wr) begin
      ring_mem[ring_waddr] <= sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sort_re) begin
      sort_rdata_q <= sort_mem[sort_raddr];
    end
    if (sort_we) begin
      sort_mem[sort_waddr] <= sort_wdata;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sliding_window_p95_tracker.sv
// ----------------------------------------------------------------------------
// Sliding window p95 tracker
// Keeps the last 4096 latency samples and reports the nearest-rank p95.
//
//   channel    dir   fields
//   sample_i   in    latency_us[23:0]
//   result_o   out   last_us[23:0], p95_us[23:0], sample_count[12:0]
//
// Each item runs from its transfer to the next ready through passes over the
// sorted store: an insert pass while the window fills, and a delete pass and
// an insert pass once full. The passes stream through the sorted store, one
// read and one shifted write a cycle. No clearing pass after reset.
// A result waits in the register until taken; the next sample is accepted
// meanwhile and its result waits in the last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_p95_tracker (
  input  logic         clk_i,
  input  logic         rst_ni,
  swpt_sample_if.sink  sample_i,
  swpt_result_if.source result_o
);
  import swpt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  swpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  swpt_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .latency_us_i   (sample_i.latency_us),
    .last_us_o      (result_o.last_us),
    .p95_us_o       (result_o.p95_us),
    .sample_count_o (result_o.sample_count)
  );

endmodule

`default_nettype wire

>>> hdl/swpt_checker.sv
// ----------------------------------------------------------------------------
// Sliding window p95 tracker port checker
// Port-level properties of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sliding_window_p95_tracker_defines.svh"

module swpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [swpt_pkg::SAMPLE_W-1:0] last_us_i,
  input logic [swpt_pkg::SAMPLE_W-1:0] p95_us_i,
  input logic [swpt_pkg::CNT_W-1:0]    sample_count_i
);
  import swpt_pkg::*;

  logic                          in_xfer;
  logic                          out_stall;
  logic                          count_ok;
  logic                          lone_out;
  logic [2*SAMPLE_W+CNT_W-1:0]   res_bits;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign count_ok  = (sample_count_i != '0) && (sample_count_i <= CNT_W'(WINDOW));
  assign lone_out  = out_valid_i && (sample_count_i == CNT_W'(1));
  assign res_bits  = {last_us_i, p95_us_i, sample_count_i};

  `SWP_ASSERT_NEXT(a_result_hold, out_stall, out_valid_i && $stable(res_bits), "result moved")
  `SWP_ASSERT_IMP(a_count_range, out_valid_i, count_ok, "sample count out of range")
  `SWP_ASSERT_IMP(a_single_sample, lone_out, p95_us_i == last_us_i, "p95 not the lone sample")
  `SWP_ASSERT_NEXT(a_busy_after_accept, in_xfer, !in_ready_i, "ready just after a transfer")

endmodule

bind sliding_window_p95_tracker swpt_checker u_swpt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .last_us_i      (result_o.last_us),
  .p95_us_i       (result_o.p95_us),
  .sample_count_i (result_o.sample_count)
);

`default_nettype wire
